[hdl/fps_pkg.sv]
// Shared types and constants for the FIFO process scheduler.
`timescale 1ns / 1ps
package fps_pkg;
  localparam int MaxTasks    = 16;
  localparam int MaxIoEvents = 8;
  localparam int TimeBits    = 16;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_SETREQ = 2'd1;
  localparam logic [1:0] ACT_ADDIO  = 2'd2;

  localparam logic [2:0] STEP_NONE  = 3'd0;
  localparam logic [2:0] STEP_ADMIT = 3'd1;
  localparam logic [2:0] STEP_IRQ   = 3'd2;
  localparam logic [2:0] STEP_BEGIN = 3'd3;
  localparam logic [2:0] STEP_CONT  = 3'd4;
  localparam logic [2:0] STEP_IOREQ = 3'd5;
  localparam logic [2:0] STEP_FIN   = 3'd6;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_READY   = 3'd2;
  localparam logic [2:0] ST_RUN     = 3'd3;
  localparam logic [2:0] ST_BLOCKED = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;
  localparam logic [2:0] ST_IRQ     = 3'd6;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  task_id;
    logic        task_ok;
    logic [31:0] time_value;
    logic        arr_ok;
    logic [7:0]  arr_task;
    logic        irq_ok;
    logic [7:0]  irq_task;
  } cmd_t;
endpackage

[hdl/fps_ram.sv]
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module fps_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hdl/fps_front.sv]
// Front end: range-check the input transaction and queue it for the back end.
`timescale 1ns / 1ps
module fps_front import fps_pkg::*; #(
  parameter int MaxT = MaxTasks,
  parameter int TBits = TimeBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_task_id,
  input  logic [15:0] in_time_value,
  input  logic        in_arrival_valid,
  input  logic [3:0]  in_arrival_task,
  input  logic        in_irq_valid,
  input  logic [3:0]  in_irq_task,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);
  cmd_t c;
  cmd_t buf_r [2];
  logic [1:0] cnt_r;
  logic       rp_r, wp_r;

  always_comb begin
    c = '0;
    c.action     = in_action;
    c.task_id    = 8'(in_task_id);
    c.task_ok    = 32'(in_task_id) < MaxT;
    c.time_value = 32'(in_time_value) & 32'((33'd1 << TBits) - 33'd1);
    c.arr_ok     = in_arrival_valid && (32'(in_arrival_task) < MaxT);
    c.arr_task   = 8'(in_arrival_task);
    c.irq_ok     = in_irq_valid && (32'(in_irq_task) < MaxT);
    c.irq_task   = 8'(in_irq_task);
  end

  assign in_ready = cnt_r != 2'd2;
  assign q_valid  = cnt_r != 2'd0;
  assign q_cmd    = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rp_r <= 1'b0; wp_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(q_pop);
    end
    if (in_valid && in_ready) buf_r[wp_r] <= c;
  end
endmodule

[hdl/fps_back.sv]
// Back end: scheduler state, task tables and the three task queues.
`timescale 1ns / 1ps
module fps_back import fps_pkg::*; #(
  parameter int MaxT = MaxTasks,
  parameter int MaxEv = MaxIoEvents,
  parameter int TBits = TimeBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_step_action,
  output logic [3:0]  out_acted_task,
  output logic        out_io_request_valid,
  output logic [2:0]  out_io_event_slot,
  output logic [4:0]  out_finished_count,
  output logic        out_cpu_busy
);
  localparam int TW = $clog2(MaxT);
  localparam int EW = (MaxEv > 1) ? $clog2(MaxEv) : 1;
  localparam int CW = $clog2(MaxEv + 1);
  localparam int QW = $clog2(MaxT + 1);
  localparam int AW = $clog2(MaxT * MaxEv);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  logic [1:0] state_r;

  logic [2:0]       status_r   [MaxT];
  logic [TBits-1:0] run_r      [MaxT];
  logic [EW:0]      ev_head_r  [MaxT];
  logic [CW-1:0]    ev_cnt_r   [MaxT];
  logic [TW-1:0]    aq_r [MaxT], iq_r [MaxT], rq_r [MaxT];
  logic [TW-1:0]    aq_h_r, iq_h_r, rq_h_r;
  logic [QW-1:0]    aq_n_r, iq_n_r, rq_n_r;
  logic [TW-1:0]    run_task_r;
  logic             busy_r;
  logic [4:0]       fin_r;
  cmd_t             cmd_r;

  // Required time and event times live in RAM; read while the transaction is popped.
  logic             req_we, ev_we;
  logic [TBits-1:0] req_rd, ev_rd;
  logic [AW-1:0]    ev_waddr, ev_raddr;
  logic [TW-1:0]    t_id, r_t;
  logic [EW-1:0]    r_head;

  assign t_id   = q_cmd.task_id[TW-1:0];
  assign r_t    = run_task_r;
  assign r_head = ev_head_r[run_task_r][EW-1:0];
  assign req_we = (state_r == S_IDLE) && q_valid && !out_valid &&
                  q_cmd.action == ACT_SETREQ && q_cmd.task_ok;
  assign ev_we  = (state_r == S_IDLE) && q_valid && !out_valid &&
                  q_cmd.action == ACT_ADDIO && q_cmd.task_ok &&
                  32'(ev_cnt_r[t_id]) < MaxEv;
  assign ev_waddr = AW'(32'(t_id) * MaxEv + 32'(ev_cnt_r[t_id]));
  assign ev_raddr = AW'(32'(r_t) * MaxEv + 32'(r_head));

  fps_ram #(.Width(TBits), .Depth(MaxT)) u_req (
    .clk, .we(req_we), .waddr(t_id), .wdata(q_cmd.time_value[TBits-1:0]),
    .raddr(r_t), .rdata(req_rd));
  fps_ram #(.Width(TBits), .Depth(MaxT * MaxEv)) u_ev (
    .clk, .we(ev_we), .waddr(ev_waddr), .wdata(q_cmd.time_value[TBits-1:0]),
    .raddr(ev_raddr), .rdata(ev_rd));

  assign q_pop = (state_r == S_IDLE) && q_valid && !out_valid;

  logic [TW-1:0] a_t, i_t;
  logic          arr_in, irq_in;
  logic [TBits-1:0] rt;
  logic          hit_io;
  assign a_t = cmd_r.arr_task[TW-1:0];
  assign i_t = cmd_r.irq_task[TW-1:0];
  assign arr_in = cmd_r.arr_ok && status_r[a_t] == ST_NONE;
  assign irq_in = cmd_r.irq_ok && status_r[i_t] == ST_BLOCKED;
  assign rt = run_r[r_t] + TBits'(1);
  assign hit_io = (32'(ev_head_r[r_t]) < 32'(ev_cnt_r[r_t])) && ev_rd == rt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < MaxT; i++) begin
        status_r[i] <= ST_NONE; run_r[i] <= '0;
        ev_head_r[i] <= '0; ev_cnt_r[i] <= '0;
      end
      aq_h_r <= '0; iq_h_r <= '0; rq_h_r <= '0;
      aq_n_r <= '0; iq_n_r <= '0; rq_n_r <= '0;
      run_task_r <= '0; busy_r <= 1'b0; fin_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_cmd;
            if (ev_we) ev_cnt_r[t_id] <= ev_cnt_r[t_id] + CW'(1);
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          logic [QW-1:0] an, in_n, rn;
          logic [TW-1:0] ah, ih, rh;
          logic [2:0]    stp;
          logic [TW-1:0] act;
          logic          ioreq;
          logic [EW-1:0] slot;
          an = aq_n_r; in_n = iq_n_r; rn = rq_n_r;
          ah = aq_h_r; ih = iq_h_r; rh = rq_h_r;
          stp = STEP_NONE; act = '0; ioreq = 1'b0; slot = '0;
          if (cmd_r.action == ACT_TICK) begin
            if (arr_in) begin
              status_r[a_t] <= ST_NEW;
              aq_r[TW'(ah + TW'(an))] <= a_t; an = an + QW'(1);
            end
            if (irq_in) begin
              status_r[i_t] <= ST_IRQ;
              iq_r[TW'(ih + TW'(in_n))] <= i_t; in_n = in_n + QW'(1);
            end
            if (!busy_r) begin
              if (an != 0) begin
                act = (aq_n_r == 0) ? a_t : aq_r[ah];
                ah = ah + TW'(1); an = an - QW'(1);
                status_r[act] <= ST_READY;
                rq_r[TW'(rh + TW'(rn))] <= act; rn = rn + QW'(1);
                stp = STEP_ADMIT;
              end else if (in_n != 0) begin
                act = (iq_n_r == 0) ? i_t : iq_r[ih];
                ih = ih + TW'(1); in_n = in_n - QW'(1);
                status_r[act] <= ST_READY;
                rq_r[TW'(rh + TW'(rn))] <= act; rn = rn + QW'(1);
                stp = STEP_IRQ;
              end else if (rn != 0) begin
                act = rq_r[rh];
                rh = rh + TW'(1); rn = rn - QW'(1);
                status_r[act] <= ST_RUN;
                run_task_r <= act; busy_r <= 1'b1;
                stp = STEP_BEGIN;
              end
            end else begin
              act = r_t;
              run_r[r_t] <= rt;
              if (hit_io) begin
                ev_head_r[r_t] <= ev_head_r[r_t] + (EW+1)'(1);
                status_r[r_t] <= ST_BLOCKED; busy_r <= 1'b0;
                stp = STEP_IOREQ; ioreq = 1'b1; slot = r_head;
              end else if (rt == req_rd) begin
                status_r[r_t] <= ST_DONE; busy_r <= 1'b0;
                fin_r <= fin_r + 5'd1;
                stp = STEP_FIN;
              end else begin
                stp = STEP_CONT;
              end
            end
          end
          aq_n_r <= an; iq_n_r <= in_n; rq_n_r <= rn;
          aq_h_r <= ah; iq_h_r <= ih; rq_h_r <= rh;
          out_step_action      <= stp;
          out_acted_task       <= 4'(act);
          out_io_request_valid <= ioreq;
          out_io_event_slot    <= 3'(slot);
          out_finished_count   <= fin_r + 5'(stp == STEP_FIN);
          // Busy after the step unless the running task just blocked or finished.
          out_cpu_busy         <= (stp == STEP_BEGIN) ||
                                  (busy_r && stp != STEP_IOREQ && stp != STEP_FIN);
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_IDLE && out_valid) else $error("exec stuck");
  a_no_pop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_pop) else $error("pop with pending result");
  a_ioreq_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_io_request_valid |-> out_io_event_slot == 3'd0)
    else $error("slot without request");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(aq_n_r) <= MaxT && 32'(iq_n_r) <= MaxT && 32'(rq_n_r) <= MaxT)
    else $error("queue overflow");
`endif
endmodule

[hdl/fifo_process_scheduler_core.sv]
// Top level of the FIFO process scheduler.
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready   | action, task, time, arrival, irq
//  out_    | output    | out_valid/out_ready | step, task, io request, counts
// The back end pops a transaction while reading the time RAMs, updates tables and
// queues in the next cycle, then holds the result; the next pop waits until that
// result is taken. A two-entry queue sits before the back end. Reset (rst_n low,
// synchronous) clears status, queues and counters; stored required and event times
// are kept. A held result stalls the back end only; the front queue still accepts
// up to two transactions.
`timescale 1ns / 1ps
module fifo_process_scheduler_core import fps_pkg::*; #(
  parameter int MaxT  = MaxTasks,
  parameter int MaxEv = MaxIoEvents,
  parameter int TBits = TimeBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_task_id,
  input  logic [15:0] in_time_value,
  input  logic        in_arrival_valid,
  input  logic [3:0]  in_arrival_task,
  input  logic        in_irq_valid,
  input  logic [3:0]  in_irq_task,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_step_action,
  output logic [3:0]  out_acted_task,
  output logic        out_io_request_valid,
  output logic [2:0]  out_io_event_slot,
  output logic [4:0]  out_finished_count,
  output logic        out_cpu_busy
);
  logic q_valid, q_pop;
  cmd_t q_cmd;

  fps_front #(.MaxT(MaxT), .TBits(TBits)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_task_id, .in_time_value,
    .in_arrival_valid, .in_arrival_task, .in_irq_valid, .in_irq_task,
    .q_valid, .q_cmd, .q_pop);

  fps_back #(.MaxT(MaxT), .MaxEv(MaxEv), .TBits(TBits)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .out_valid, .out_ready,
    .out_step_action, .out_acted_task, .out_io_request_valid,
    .out_io_event_slot, .out_finished_count, .out_cpu_busy);
endmodule

[test/fifo_process_scheduler_core_test.sv]
// Self-checking regression for the FIFO process scheduler core.
`timescale 1ns / 1ps
module fifo_process_scheduler_core_test;
  import fps_pkg::*;

  localparam int NT = 16;
  localparam int NE = 8;
  localparam int ExpDepth = 4096;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [3:0]  in_task_id;
  logic [15:0] in_time_value;
  logic        in_arrival_valid;
  logic [3:0]  in_arrival_task;
  logic        in_irq_valid;
  logic [3:0]  in_irq_task;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_step_action;
  logic [3:0]  out_acted_task;
  logic        out_io_request_valid;
  logic [2:0]  out_io_event_slot;
  logic [4:0]  out_finished_count;
  logic        out_cpu_busy;

  typedef struct packed {
    logic [2:0] step;
    logic [3:0] acted;
    logic       ioreq;
    logic [2:0] slot;
    logic [4:0] fin;
    logic       busy;
  } sched_result_t;

  fifo_process_scheduler_core u_dut (.*);

  // scheduler mirror
  logic [2:0]  status_m [NT];
  logic [15:0] run_m [NT];
  logic [15:0] req_m [NT];
  logic [15:0] ev_m [NT][NE];
  int          ev_head_m [NT];
  int          ev_cnt_m [NT];
  logic [3:0]  arr_q_m [NT];
  logic [3:0]  irq_q_m [NT];
  logic [3:0]  rdy_q_m [NT];
  int          arr_h_m = 0, arr_n_m = 0;
  int          irq_h_m = 0, irq_n_m = 0;
  int          rdy_h_m = 0, rdy_n_m = 0;
  logic [3:0]  running_m;
  logic        busy_m;
  logic [4:0]  fin_m;

  sched_result_t exp_mem [ExpDepth];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int sent = 0;
  int got = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int step_seen [7];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic sched_result_t predict_step(logic [1:0] act, logic [3:0] tid,
      logic [15:0] tv, logic av, logic [3:0] at, logic iv, logic [3:0] it);
    sched_result_t r;
    logic [3:0] t;
    r = '0;
    if (act == ACT_SETREQ) begin
      req_m[tid] = tv;
    end else if (act == ACT_ADDIO) begin
      if (ev_cnt_m[tid] < NE) begin
        ev_m[tid][ev_cnt_m[tid]] = tv;
        ev_cnt_m[tid]++;
      end
    end else if (act == ACT_TICK) begin
      if (av && status_m[at] == ST_NONE) begin
        status_m[at] = ST_NEW;
        arr_q_m[(arr_h_m + arr_n_m) % NT] = at; arr_n_m++;
      end
      if (iv && status_m[it] == ST_BLOCKED) begin
        status_m[it] = ST_IRQ;
        irq_q_m[(irq_h_m + irq_n_m) % NT] = it; irq_n_m++;
      end
      if (!busy_m) begin
        if (arr_n_m > 0) begin
          t = arr_q_m[arr_h_m]; arr_h_m = (arr_h_m + 1) % NT; arr_n_m--;
          status_m[t] = ST_READY;
          rdy_q_m[(rdy_h_m + rdy_n_m) % NT] = t; rdy_n_m++;
          r.step = STEP_ADMIT; r.acted = t;
        end else if (irq_n_m > 0) begin
          t = irq_q_m[irq_h_m]; irq_h_m = (irq_h_m + 1) % NT; irq_n_m--;
          status_m[t] = ST_READY;
          rdy_q_m[(rdy_h_m + rdy_n_m) % NT] = t; rdy_n_m++;
          r.step = STEP_IRQ; r.acted = t;
        end else if (rdy_n_m > 0) begin
          t = rdy_q_m[rdy_h_m]; rdy_h_m = (rdy_h_m + 1) % NT; rdy_n_m--;
          status_m[t] = ST_RUN;
          running_m = t;
          busy_m = 1;
          r.step = STEP_BEGIN; r.acted = t;
        end
      end else begin
        t = running_m;
        run_m[t] = run_m[t] + 16'd1;
        r.acted = t;
        if (ev_head_m[t] < ev_cnt_m[t] && ev_m[t][ev_head_m[t]] == run_m[t]) begin
          r.slot = 3'(ev_head_m[t]);
          ev_head_m[t]++;
          status_m[t] = ST_BLOCKED;
          busy_m = 0;
          r.step = STEP_IOREQ; r.ioreq = 1;
        end else if (run_m[t] == req_m[t]) begin
          status_m[t] = ST_DONE;
          busy_m = 0;
          fin_m++;
          r.step = STEP_FIN;
        end else begin
          r.step = STEP_CONT;
        end
      end
    end
    r.fin = fin_m;
    r.busy = busy_m;
    return r;
  endfunction

  // drive one transaction and hold it until accepted; valid stays up for the next one unless an idle gap is drawn
  task automatic send_item(logic [1:0] act, logic [3:0] tid, logic [15:0] tv,
      logic av, logic [3:0] at, logic iv, logic [3:0] it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act; in_task_id <= tid; in_time_value <= tv;
    in_arrival_valid <= av; in_arrival_task <= at;
    in_irq_valid <= iv; in_irq_task <= it;
    do @(posedge clk); while (!in_ready);
    exp_mem[exp_wr % ExpDepth] = predict_step(act, tid, tv, av, at, iv, it);
    exp_wr++;
    sent++;
  endtask

  task automatic tick(logic av, logic [3:0] at, logic iv, logic [3:0] it);
    send_item(ACT_TICK, 4'($urandom), 16'($urandom), av, at, iv, it);
  endtask

  always @(posedge clk) begin
    sched_result_t a, e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        a = {out_step_action, out_acted_task, out_io_request_valid,
             out_io_event_slot, out_finished_count, out_cpu_busy};
        got++;
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result %h", $time, a);
          errors++;
        end else begin
          e = exp_mem[exp_rd % ExpDepth];
          exp_rd++;
          step_seen[a.step % 7]++;
          if (a !== e) begin
            $display("%0t: mismatch expected step=%0d task=%0d io=%0d slot=%0d fin=%0d busy=%0d",
                     $time, e.step, e.acted, e.ioreq, e.slot, e.fin, e.busy);
            $display("%0t:          actual   step=%0d task=%0d io=%0d slot=%0d fin=%0d busy=%0d",
                     $time, a.step, a.acted, a.ioreq, a.slot, a.fin, a.busy);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Ticks that keep the machine moving: irq for blocked tasks, sometimes noise.
  task automatic run_ticks(int n);
    logic [3:0] blk;
    logic iv;
    logic [3:0] at;
    logic av;
    for (int i = 0; i < n; i++) begin
      iv = 0; blk = 4'($urandom);
      for (int k = 0; k < NT; k++)
        if (status_m[k] == ST_BLOCKED && $urandom_range(3) == 0) begin
          iv = 1; blk = 4'(k);
        end
      if ($urandom_range(9) == 0) iv = 1'($urandom);
      // only tasks with a required time may arrive
      at = 4'($urandom);
      av = ($urandom_range(7) == 0) && (req_m[at] !== 'x);
      tick(av, at, iv, blk);
    end
  endtask

  // Define a batch of tasks with short times; events are mostly ascending.
  task automatic define_tasks(int maxreq);
    logic [15:0] req, tv;
    logic hit;
    int n;
    for (int k = 0; k < NT; k++) begin
      if (status_m[k] != ST_NONE) continue;
      req = 16'($urandom_range(1, maxreq));
      // keep events off the required time so every task can finish
      do begin
        hit = 0;
        for (int j = 0; j < ev_cnt_m[k]; j++)
          if (ev_m[k][j] == req) begin
            req = req + 16'd1; hit = 1;
          end
      end while (hit);
      send_item(ACT_SETREQ, 4'(k), req, 1'($urandom), 4'($urandom), 1'($urandom),
                4'($urandom));
      n = (ev_cnt_m[k] < NE) ? $urandom_range(0, 3) : 0;
      tv = 0;
      for (int j = 0; j < n; j++) begin
        tv = ($urandom_range(3) == 0) ? 16'($urandom) : tv + 16'($urandom_range(1, 4));
        if (tv == req) tv = tv + 16'd1;
        send_item(ACT_ADDIO, 4'(k), tv, 1'($urandom), 4'($urandom), 1'($urandom),
                  4'($urandom));
      end
    end
  endtask

  task automatic settle;
    in_valid <= 0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed;
    // full event list, overflow append, event equal to required time
    send_item(ACT_SETREQ, 4'd0, 16'd3, 0, 0, 0, 0);
    for (int j = 0; j < NE + 1; j++)
      send_item(ACT_ADDIO, 4'd0, (j == 0) ? 16'd3 : 16'd5 + 16'(j), 0, 0, 0, 0);
    send_item(ACT_SETREQ, 4'd15, 16'hFFFF, 1, 4'd15, 1, 4'd15);
    send_item(ACT_ADDIO, 4'd15, 16'd1, 0, 0, 0, 0);
    send_item(2'd3, 4'd7, 16'hFFFF, 1, 4'd7, 1, 4'd7);
    tick(1, 4'd0, 1, 4'd0);  // stray interrupt
    tick(1, 4'd0, 0, 0);     // repeated arrival
    tick(1, 4'd15, 0, 0);
    tick(0, 0, 0, 0);
    repeat (4) tick(0, 0, 0, 0);
    tick(0, 0, 1, 4'd0);
    tick(0, 0, 1, 4'd15);
    // move both required times to values ahead of the run times reached so far
    send_item(ACT_SETREQ, 4'd0, 16'd30, 0, 0, 0, 0);
    send_item(ACT_SETREQ, 4'd15, 16'd9, 0, 0, 0, 0);
    repeat (6) tick(0, 0, 0, 0);
  endtask

  task automatic test_random(int items);
    int start;
    start = sent;
    while (sent - start < items) begin
      if ($urandom_range(5) == 0) define_tasks(($urandom_range(15) == 0) ? 300 : 12);
      for (int k = 0; k < 3; k++) begin
        logic [3:0] t;
        t = 4'($urandom);
        if (status_m[t] == ST_NONE && ev_cnt_m[t] + 0 >= 0 && req_m[t] !== 'x)
          tick(1, t, 0, 0);
      end
      run_ticks($urandom_range(5, 30));
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; out_ready = 0;
    in_action = 0; in_task_id = 0; in_time_value = 0;
    in_arrival_valid = 0; in_arrival_task = 0; in_irq_valid = 0; in_irq_task = 0;
    for (int k = 0; k < NT; k++) begin
      status_m[k] = ST_NONE; run_m[k] = 0; req_m[k] = 'x;
      ev_head_m[k] = 0; ev_cnt_m[k] = 0;
    end
    running_m = 0; busy_m = 0; fin_m = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed;
    send_idle = 33; recv_idle = 64;
    test_random(550);
    send_idle = 64; recv_idle = 33;
    test_random(550);
    send_idle = 0; recv_idle = 0;
    test_random(550);
    settle;
    $display("Sent %0d transactions, checked %0d results; finishes %0d, io requests %0d.",
             sent, got, step_seen[STEP_FIN], step_seen[STEP_IOREQ]);
    $display("Covered admit, interrupt, begin, continue paths under three idle mixes.");
    if (errors == 0 && exp_wr == exp_rd)
      $display("fifo_process_scheduler_core regression: pass");
    else
      $display("fifo_process_scheduler_core regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("fifo_process_scheduler_core regression: fail");
    $finish;
  end
endmodule

[files.f]
hdl/fps_pkg.sv
hdl/fps_ram.sv
hdl/fps_front.sv
hdl/fps_back.sv
hdl/fifo_process_scheduler_core.sv
test/fifo_process_scheduler_core_test.sv
